// ===== design/wtsc_pkg.sv =====
`default_nettype none

package wtsc_pkg;

   localparam int unsigned WEIGHT_W  = 16;
   localparam int unsigned CLIP_W    = 6;
   localparam int unsigned KILO_W    = 3;
   localparam int unsigned REM_W     = 10;
   localparam int unsigned DIGIT_W   = 4;
   localparam int unsigned SLOT_N    = 6;
   localparam int unsigned SLOT_W    = 3;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX    = 16'd5000;
   localparam logic [WEIGHT_W-1:0] GRAMS_PER_KG  = 16'd1000;
   localparam int unsigned         KILO_STEPS    = 5;

   localparam logic [CLIP_W-1:0] CLIP_GRAMS      = 6'd55;
   localparam logic [CLIP_W-1:0] CLIP_KILOS      = 6'd57;
   localparam logic [CLIP_W-1:0] CLIP_COMMA      = 6'd59;
   localparam logic [CLIP_W-1:0] CLIP_TEEN_BASE  = 6'd10;
   localparam logic [CLIP_W-1:0] CLIP_HUND_BASE  = 6'd34;
   localparam logic [CLIP_W-1:0] CLIP_TENS_BASE  = 6'd16;

   localparam logic [SLOT_W-1:0] SLOT_KILO    = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_COMMA   = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_HUNDRED = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_TENS    = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_UNITS   = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_UNIT    = 3'd5;

   typedef struct packed {
      logic [KILO_W-1:0]  kilos;
      logic [DIGIT_W-1:0] hundreds;
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] units;
      logic [SLOT_N-1:0]  slot_mask;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/wtsc_front.sv =====
`default_nettype none

module wtsc_front
   import wtsc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [WEIGHT_W-1:0] req_weight_grams,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output entry_type                push_entry
);

   logic              s1_valid_ff, s1_valid_in;
   logic [KILO_W-1:0] s1_kilos_ff, s1_kilos_in;
   logic [REM_W-1:0]  s1_rem_ff, s1_rem_in;

   logic              accept;
   logic              in_range;
   logic [KILO_W-1:0] kilos;
   logic [WEIGHT_W-1:0] rem_full;

   logic [15:0]       prod_h;
   logic [DIGIT_W-1:0] hundreds;
   logic [REM_W-1:0]  rem_h;
   logic [6:0]        rem_d;
   logic [13:0]       prod_d;
   logic [DIGIT_W-1:0] tens;
   logic [6:0]        units_full;
   logic [DIGIT_W-1:0] units;

   assign req_stall = s1_valid_ff && !push_ready;
   assign accept    = req_valid && !req_stall;
   assign in_range  = (req_weight_grams != '0) && (req_weight_grams <= WEIGHT_MAX);

   always_comb begin
      kilos = '0;
      for (int i = 1; i <= KILO_STEPS; i++) begin
         kilos = kilos + KILO_W'(req_weight_grams >= WEIGHT_W'(i * 1000));
      end
      rem_full = req_weight_grams - WEIGHT_W'(kilos) * GRAMS_PER_KG;
   end

   always_comb begin
      s1_kilos_in = s1_kilos_ff;
      s1_rem_in   = s1_rem_ff;
      s1_valid_in = s1_valid_ff && !push_ready;
      if (accept && in_range) begin
         s1_valid_in = 1'b1;
         s1_kilos_in = kilos;
         s1_rem_in   = rem_full[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_kilos_ff <= s1_kilos_in;
      s1_rem_ff   <= s1_rem_in;
   end

   // split remainder into digits by reciprocal multiply
   always_comb begin
      prod_h     = 16'(s1_rem_ff) * 16'd41;
      hundreds   = prod_h[15:12];
      rem_h      = s1_rem_ff - REM_W'(hundreds) * 10'd100;
      rem_d      = rem_h[6:0];
      prod_d     = 14'(rem_d) * 14'd103;
      tens       = prod_d[13:10];
      units_full = rem_d - 7'(tens) * 7'd10;
      units      = units_full[DIGIT_W-1:0];
   end

   always_comb begin
      push_entry.kilos    = s1_kilos_ff;
      push_entry.hundreds = hundreds;
      push_entry.tens     = tens;
      push_entry.units    = units;
      push_entry.slot_mask[SLOT_KILO]    = (s1_kilos_ff != '0);
      push_entry.slot_mask[SLOT_COMMA]   = (s1_kilos_ff != '0) && (s1_rem_ff != '0);
      push_entry.slot_mask[SLOT_HUNDRED] = (hundreds != '0);
      push_entry.slot_mask[SLOT_TENS]    = (tens != '0);
      push_entry.slot_mask[SLOT_UNITS]   = (units != '0) && (tens != 4'd1);
      push_entry.slot_mask[SLOT_UNIT]    = 1'b1;
   end

   assign push_valid = s1_valid_ff;

endmodule

`default_nettype wire

// ===== design/wtsc_queue.sv =====
`default_nettype none

module wtsc_queue
   import wtsc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire entry_type push_entry,
   output logic           pop_valid,
   input  wire logic      pop,
   output entry_type      pop_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/wtsc_back.sv =====
`default_nettype none

module wtsc_back
   import wtsc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire entry_type         head_entry,
   output logic                   head_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CLIP_W-1:0]      rsp_clip_number,
   output logic                   rsp_last_clip
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CLIP_W-1:0] clip_ff, clip_in;
   logic              last_ff, last_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;

   logic              load;
   logic [SLOT_N-1:0] avail;
   logic [SLOT_W-1:0] sel;
   logic              more_hund, more_tens;
   logic [CLIP_W-1:0] clip_sel;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int i = 0; i < SLOT_N; i++) begin
         avail[i] = head_entry.slot_mask[i] && (SLOT_W'(i) >= pos_ff);
      end
      sel = SLOT_UNIT;
      for (int i = SLOT_N - 1; i >= 0; i--) begin
         if (avail[i]) begin
            sel = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      more_hund = (head_entry.tens != '0) || (head_entry.units != '0);
      more_tens = (head_entry.units != '0);
      case (sel)
         SLOT_KILO: begin
            clip_sel = CLIP_W'(head_entry.kilos);
         end
         SLOT_COMMA: begin
            clip_sel = CLIP_COMMA;
         end
         SLOT_HUNDRED: begin
            clip_sel = CLIP_HUND_BASE + {1'b0, head_entry.hundreds, 1'b0}
                       + CLIP_W'(more_hund);
         end
         SLOT_TENS: begin
            if (head_entry.tens == 4'd1) begin
               clip_sel = CLIP_TEEN_BASE + CLIP_W'(head_entry.units);
            end else begin
               clip_sel = CLIP_TENS_BASE + {1'b0, head_entry.tens, 1'b0}
                          + CLIP_W'(more_tens);
            end
         end
         SLOT_UNITS: begin
            clip_sel = CLIP_W'(head_entry.units);
         end
         SLOT_UNIT: begin
            clip_sel = (head_entry.kilos != '0) ? CLIP_KILOS : CLIP_GRAMS;
         end
         default: begin
            clip_sel = CLIP_GRAMS;
         end
      endcase
   end

   assign head_pop = load && (sel == SLOT_UNIT);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      clip_in      = clip_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         clip_in      = clip_sel;
         last_in      = (sel == SLOT_UNIT);
         pos_in       = (sel == SLOT_UNIT) ? '0 : sel + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
      clip_ff <= clip_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_clip_number = clip_ff;
   assign rsp_last_clip   = last_ff;

endmodule

`default_nettype wire

// ===== design/weight_to_spoken_clip_sequence.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_weight_grams[15:0]
// rsp_      out        rsp_valid/rsp_stall  rsp_clip_number[5:0], rsp_last_clip
//
// A weight of 1..5000 gives 2 to 6 clip transfers, one per cycle while rsp_stall is
// low; each clip passes through the single output register of the back end.
// Out-of-range weights are accepted and give no transfers.
// A first clip passes the front register, the queue and the output register.
// Reset is synchronous and clears the front register, queue and output register.
// A stall on rsp_ holds the clip; the queue keeps req_ flowing until it fills.
`default_nettype none

module weight_to_spoken_clip_sequence
   import wtsc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [WEIGHT_W-1:0] req_weight_grams,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [CLIP_W-1:0]        rsp_clip_number,
   output logic                     rsp_last_clip
);

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      head_valid, head_pop;
   entry_type head_entry;

   wtsc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_weight_grams (req_weight_grams),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   wtsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .pop_entry  (head_entry)
   );

   wtsc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .head_pop        (head_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_clip_number (rsp_clip_number),
      .rsp_last_clip   (rsp_last_clip)
   );

endmodule

`default_nettype wire

// ===== design/wtsc_checker.sv =====
`default_nettype none

module wtsc_checker
   import wtsc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic [WEIGHT_W-1:0] req_weight_grams,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic [CLIP_W-1:0]   rsp_clip_number,
   input  wire logic                rsp_last_clip
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_clip_number)
                                 && $stable(rsp_last_clip))
      else $error("stalled clip transfer changed");

   a_last_is_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_clip |-> rsp_clip_number == CLIP_GRAMS
                                     || rsp_clip_number == CLIP_KILOS)
      else $error("last clip is not a unit word");

   a_unit_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_clip_number == CLIP_GRAMS || rsp_clip_number == CLIP_KILOS)
      |-> rsp_last_clip)
      else $error("unit word not marked last");

   a_no_weight_transfer_ends_with_comma: assert property (@(posedge clock)
      disable iff (reset)
      rsp_valid && !rsp_stall && rsp_clip_number == CLIP_COMMA
      |=> !(rsp_valid && rsp_last_clip))
      else $error("comma followed directly by unit word");

endmodule

bind weight_to_spoken_clip_sequence wtsc_checker u_checker (.*);

`default_nettype wire
